@@ sv/stp_pkg.sv @@
// Shared types and constants of the section time profiler.
package stp_pkg;

    localparam int IDX_W      = 6;
    localparam int TICK_W     = 32;
    localparam int CALLS_W    = 16;
    localparam int AVG_W      = 40;
    localparam int LABEL_W    = 64;
    localparam int ALPHA_W    = 9;
    localparam int FRAMES_W   = 8;
    localparam int CFG_ADDR_W = 2;

    localparam logic [ALPHA_W-1:0]    Q_ONE  = 9'd256;
    localparam logic [FRAMES_W-1:0]   FRAMES_MAX = 8'd255;
    localparam logic [CALLS_W-1:0]    CALLS_MAX  = 16'hFFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Input action codes.
    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_FRAME = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_RAMP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_STEADY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_FRAMES  = 2'd2;

    localparam logic [ALPHA_W-1:0]  RST_ALPHA_RAMP   = 9'd77;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA_STEADY = 9'd26;
    localparam logic [FRAMES_W-1:0] RST_RAMP_FRAMES  = 8'd10;

    typedef struct packed {
        logic [1:0]         action;
        logic [IDX_W-1:0]   section_index;
        logic [TICK_W-1:0]  timestamp;
        logic [LABEL_W-1:0] frame_id;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   out_section;
        logic [TICK_W-1:0]  current_ticks;
        logic [CALLS_W-1:0] calls;
        logic [TICK_W-1:0]  min_ticks;
        logic [TICK_W-1:0]  max_ticks;
        logic [AVG_W-1:0]   avg_q8;
        logic [LABEL_W-1:0] frame_label;
        logic [TICK_W-1:0]  frame_ticks;
        logic               last;
    } t_out_word;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_BEGIN,
        CMD_END,
        CMD_FRAME,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [IDX_W-1:0]   idx;
        logic [TICK_W-1:0]  ts;
        logic [LABEL_W-1:0] label;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD,
        BK_CALC,
        BK_WR
    } t_bk_state;

    // One row of per-section state in the section memory.
    typedef struct packed {
        logic               active;
        logic [TICK_W-1:0]  start;
        logic [TICK_W-1:0]  accum;
        logic [CALLS_W-1:0] calls;
        logic [TICK_W-1:0]  min_t;
        logic [TICK_W-1:0]  max_t;
        logic [AVG_W-1:0]   avg;
        logic               seen;
    } t_row;

endpackage

@@ sv/stp_front.sv @@
// Input stage: accepts event words, classifies them and queues commands.
module stp_front #(
    parameter int SECTIONS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  stp_pkg::t_in_word i_data,
    output logic             o_q_valid,
    output stp_pkg::t_cmd    o_q_cmd,
    input  logic             i_q_pop
);

    stp_pkg::t_cmd r_q [stp_pkg::Q_DEPTH];
    logic [stp_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [stp_pkg::Q_PTR_W:0]   r_count;
    stp_pkg::t_cmd w_cmd;
    logic w_push, w_pop, w_in_range;

    assign o_ready   = (r_count != (stp_pkg::Q_PTR_W+1)'(stp_pkg::Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_q[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    assign w_in_range = ({1'b0, i_data.section_index} < 7'(SECTIONS));

    always_comb begin
        w_cmd.idx   = i_data.section_index;
        w_cmd.ts    = i_data.timestamp;
        w_cmd.label = i_data.frame_id;
        case (i_data.action)
            stp_pkg::ACT_BEGIN: w_cmd.kind = w_in_range ? stp_pkg::CMD_BEGIN : stp_pkg::CMD_NOP;
            stp_pkg::ACT_END:   w_cmd.kind = w_in_range ? stp_pkg::CMD_END : stp_pkg::CMD_NOP;
            stp_pkg::ACT_FRAME: w_cmd.kind = stp_pkg::CMD_FRAME;
            stp_pkg::ACT_CLEAR: w_cmd.kind = stp_pkg::CMD_CLEAR;
            default:            w_cmd.kind = stp_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/stp_back.sv @@
// Execution stage: section memory, statistics update and result register.
module stp_back #(
    parameter int SECTIONS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  stp_pkg::t_cmd                      i_q_cmd,
    output logic                               o_q_pop,
    input  logic                               i_cfg_we,
    input  logic [stp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [stp_pkg::ALPHA_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output stp_pkg::t_out_word                 o_data
);

    localparam int SIDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SIDX_W-1:0] LAST_SEC = SIDX_W'(SECTIONS - 1);

    stp_pkg::t_row r_mem [SECTIONS];
    logic [SECTIONS-1:0] r_row_vld;
    stp_pkg::t_row r_rd_row;
    logic          r_rd_vld;

    stp_pkg::t_bk_state r_state, n_state;
    stp_pkg::t_cmd      r_cmd, n_cmd;
    logic [SIDX_W-1:0]  r_addr, n_addr;
    stp_pkg::t_row      r_row, n_row;
    logic [stp_pkg::TICK_W-1:0]   r_el, n_el;
    logic                          r_ema, n_ema;
    logic [48:0]                   r_p1, n_p1;
    logic [40:0]                   r_p2, n_p2;
    logic [stp_pkg::TICK_W-1:0]   r_ftot, n_ftot;
    logic [stp_pkg::TICK_W-1:0]   r_fstart, n_fstart;
    logic [stp_pkg::FRAMES_W-1:0] r_frames, n_frames;
    logic [stp_pkg::ALPHA_W-1:0]  r_alpha_ramp, r_alpha_steady;
    logic [stp_pkg::FRAMES_W-1:0] r_ramp_frames;
    logic                          r_out_valid, n_out_valid;
    stp_pkg::t_out_word            r_out, n_out;

    logic                          w_we, w_clr, w_out_free;
    stp_pkg::t_row                 w_row, w_row_in;
    logic [stp_pkg::ALPHA_W-1:0]  w_alpha_raw, w_alpha, w_inv;
    logic [32:0]                   w_sum;
    logic [49:0]                   w_ema_sum;
    logic [stp_pkg::AVG_W-1:0]    w_avg;

    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_row_in   = r_rd_vld ? r_rd_row : '0;

    assign w_alpha_raw = (r_frames < r_ramp_frames) ? r_alpha_ramp : r_alpha_steady;
    assign w_alpha     = (w_alpha_raw > stp_pkg::Q_ONE) ? stp_pkg::Q_ONE : w_alpha_raw;
    assign w_inv       = stp_pkg::Q_ONE - w_alpha;

    assign w_sum     = {1'b0, r_row.accum} + {1'b0, r_el};
    // Rounded half up: add half an LSB before dropping the eight fraction bits.
    assign w_ema_sum = {1'b0, r_p1} + {1'b0, r_p2, 8'd0} + 50'd128;
    assign w_avg     = r_ema ? w_ema_sum[47:8] : r_row.avg;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_row       = r_row;
        n_el        = r_el;
        n_ema       = r_ema;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_ftot      = r_ftot;
        n_fstart    = r_fstart;
        n_frames    = r_frames;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_clr       = 1'b0;
        w_row       = r_row;
        case (r_state)
            stp_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    case (i_q_cmd.kind)
                        stp_pkg::CMD_BEGIN, stp_pkg::CMD_END: begin
                            n_addr  = i_q_cmd.idx[SIDX_W-1:0];
                            n_state = stp_pkg::BK_RD;
                        end
                        stp_pkg::CMD_FRAME: begin
                            n_ftot   = i_q_cmd.ts - r_fstart;
                            n_fstart = i_q_cmd.ts;
                            n_addr   = '0;
                            n_state  = stp_pkg::BK_RD;
                        end
                        stp_pkg::CMD_CLEAR: begin
                            w_clr    = 1'b1;
                            n_fstart = i_q_cmd.ts;
                            n_frames = '0;
                        end
                        default: begin
                            n_state = stp_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            stp_pkg::BK_RD: begin
                n_state = stp_pkg::BK_CALC;
            end
            stp_pkg::BK_CALC: begin
                n_row   = w_row_in;
                n_state = stp_pkg::BK_IDLE;
                case (r_cmd.kind)
                    stp_pkg::CMD_BEGIN: begin
                        if (!w_row_in.active) begin
                            n_row.active = 1'b1;
                            n_row.start  = r_cmd.ts;
                            n_state      = stp_pkg::BK_WR;
                        end
                    end
                    stp_pkg::CMD_END: begin
                        if (w_row_in.active) begin
                            n_el    = r_cmd.ts - w_row_in.start;
                            n_state = stp_pkg::BK_WR;
                        end
                    end
                    stp_pkg::CMD_FRAME: begin
                        n_ema   = 1'b0;
                        n_p1    = 49'(w_inv) * 49'(w_row_in.avg);
                        n_p2    = 41'(w_alpha) * 41'(w_row_in.accum);
                        n_state = stp_pkg::BK_WR;
                        if (w_row_in.accum != '0) begin
                            if (!w_row_in.seen) begin
                                n_row.min_t = w_row_in.accum;
                                n_row.max_t = w_row_in.accum;
                                n_row.avg   = {w_row_in.accum, 8'd0};
                                n_row.seen  = 1'b1;
                            end else begin
                                if (w_row_in.accum < w_row_in.min_t) begin
                                    n_row.min_t = w_row_in.accum;
                                end
                                if (w_row_in.accum > w_row_in.max_t) begin
                                    n_row.max_t = w_row_in.accum;
                                end
                                n_ema = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_state = stp_pkg::BK_IDLE;
                    end
                endcase
            end
            stp_pkg::BK_WR: begin
                case (r_cmd.kind)
                    stp_pkg::CMD_END: begin
                        w_we         = 1'b1;
                        w_row.accum  = w_sum[32] ? '1 : w_sum[31:0];
                        w_row.calls  = (r_row.calls == stp_pkg::CALLS_MAX) ?
                                       r_row.calls : r_row.calls + 1'b1;
                        w_row.active = 1'b0;
                        n_state      = stp_pkg::BK_IDLE;
                    end
                    stp_pkg::CMD_FRAME: begin
                        if (w_out_free) begin
                            w_we        = 1'b1;
                            w_row.avg   = w_avg;
                            w_row.accum = '0;
                            w_row.calls = '0;
                            n_out_valid = 1'b1;
                            n_out.out_section   = 6'(r_addr);
                            n_out.current_ticks = r_row.accum;
                            n_out.calls         = r_row.calls;
                            n_out.min_ticks     = r_row.min_t;
                            n_out.max_ticks     = r_row.max_t;
                            n_out.avg_q8        = w_avg;
                            n_out.frame_label   = r_cmd.label;
                            n_out.frame_ticks   = r_ftot;
                            n_out.last          = (r_addr == LAST_SEC);
                            if (r_addr == LAST_SEC) begin
                                if (r_frames != stp_pkg::FRAMES_MAX) begin
                                    n_frames = r_frames + 1'b1;
                                end
                                n_state = stp_pkg::BK_IDLE;
                            end else begin
                                n_addr  = r_addr + 1'b1;
                                n_state = stp_pkg::BK_RD;
                            end
                        end
                    end
                    default: begin
                        // Begin: the row was prepared in the previous step.
                        w_we    = 1'b1;
                        n_state = stp_pkg::BK_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = stp_pkg::BK_IDLE;
            end
        endcase
    end

    // Section memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_row;
        end
        r_rd_row <= r_mem[r_addr];
        r_rd_vld <= r_row_vld[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_row_vld <= '0;
        end else if (w_we) begin
            r_row_vld[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ramp   <= stp_pkg::RST_ALPHA_RAMP;
            r_alpha_steady <= stp_pkg::RST_ALPHA_STEADY;
            r_ramp_frames  <= stp_pkg::RST_RAMP_FRAMES;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                stp_pkg::CFG_ALPHA_RAMP:   r_alpha_ramp   <= i_cfg_data;
                stp_pkg::CFG_ALPHA_STEADY: r_alpha_steady <= i_cfg_data;
                stp_pkg::CFG_RAMP_FRAMES:  r_ramp_frames  <= i_cfg_data[stp_pkg::FRAMES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stp_pkg::BK_IDLE;
            r_fstart    <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fstart    <= n_fstart;
            r_frames    <= n_frames;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_row  <= n_row;
        r_el   <= n_el;
        r_ema  <= n_ema;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_ftot <= n_ftot;
        r_out  <= n_out;
    end

endmodule

@@ sv/section_time_profiler_core.sv @@
// Top level of the section time profiler: input queue and execution stage.
//
// Event words arrive on i_valid/o_ready/i_data and results leave on
// o_valid/i_ready/o_data; a word moves when valid and ready are both high.
// Begin, end, end-frame and reset-all words go into a four-deep command
// queue, so the input side keeps taking words while the back end works or
// the receiver stalls. The back end holds per-section state in a memory with
// a registered read port.
// A begin or end word passes through pop, memory read, update and write back
// in the back end, skipping the write back when it is ignored; an out-of-range
// one and a reset-all are handled at the pop. For an end-frame word each
// section is read, goes through the registered moving-average multipliers and
// is written back while its result is loaded into the output register.
// When the receiver holds i_ready low, the result waits in the output register
// and the sweep pauses; the queue fills and then o_ready drops.
// Reset clears the queue, the output register, the frame timing and all
// section row valid bits, and loads the default smoothing registers.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_data) take effect at once.
module section_time_profiler_core #(
    parameter int SECTIONS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  stp_pkg::t_in_word              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output stp_pkg::t_out_word             o_data,
    input  logic                           i_cfg_we,
    input  logic [stp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [stp_pkg::ALPHA_W-1:0]    i_cfg_data
);

    logic          w_q_valid, w_q_pop;
    stp_pkg::t_cmd w_q_cmd;

    stp_front #(.SECTIONS(SECTIONS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .i_q_pop   (w_q_pop)
    );

    stp_back #(.SECTIONS(SECTIONS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_cmd    (w_q_cmd),
        .o_q_pop    (w_q_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

@@ sv/stp_checker.sv @@
// Port-level assertions for the section time profiler and their bind.
module stp_checker #(
    parameter int SECTIONS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input stp_pkg::t_out_word o_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // The last flag marks the highest section only.
    a_last_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.out_section == 6'(SECTIONS - 1))))
        else $error("last flag on wrong section");

    // Within a frame, sections follow in index order with the same label.
    a_sec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid && i_ready && !o_data.last) |->
            o_data.out_section == $past(o_data.out_section) + 6'd1 &&
            o_data.frame_label == $past(o_data.frame_label))
        else $error("section results out of order");

endmodule

bind section_time_profiler_core stp_checker #(.SECTIONS(SECTIONS)) u_stp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
